>>> design/scd_pkg.sv
// shared constants, types and controller encoding for the sleep countdown slot bank
`timescale 1ns / 1ps

package scd_pkg;

   localparam int SLOT_COUNT_DEFAULT = 32;

   // slots per group of the free-slot and expiry-count tree
   localparam int GROUP_SIZE = 8;

   localparam int DUR_W      = 32;
   localparam int SLOT_IDX_W = 5;
   localparam int MASK_W     = 32;
   localparam int PHASE_W    = 2;
   localparam int COUNT_W    = 6;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

endpackage

>>> design/scd_if.sv
// request and response channel interfaces of the sleep countdown slot bank
`timescale 1ns / 1ps

interface scd_req_if;
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [scd_pkg::DUR_W-1:0] duration;

   modport source (output valid, output mode, output duration, input ready);
   modport sink   (input valid, input mode, input duration, output ready);
endinterface

interface scd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [scd_pkg::SLOT_IDX_W-1:0] slot_index;
   logic                           accepted;
   logic                           full_res;
   logic                           done_now;
   logic [scd_pkg::MASK_W-1:0]     expired_mask;
   logic [scd_pkg::PHASE_W-1:0]    spinner_phase;
   logic [scd_pkg::COUNT_W-1:0]    active_count;

   modport source (output valid, output slot_index, output accepted, output full_res,
                   output done_now, output expired_mask, output spinner_phase,
                   output active_count, input ready);
   modport sink   (input valid, input slot_index, input accepted, input full_res,
                   input done_now, input expired_mask, input spinner_phase,
                   input active_count, output ready);
endinterface

>>> design/scd_datapath.sv
// slot counters, busy bits, grouped search and count tree, response registers
`timescale 1ns / 1ps

module scd_datapath #(
   parameter int SLOT_COUNT = scd_pkg::SLOT_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  scd_pkg::cmd_type               cmd,
   input  logic                           req_mode,
   input  logic [scd_pkg::DUR_W-1:0]      req_duration,
   output logic [scd_pkg::SLOT_IDX_W-1:0] rsp_slot_index,
   output logic                           rsp_accepted,
   output logic                           rsp_full_res,
   output logic                           rsp_done_now,
   output logic [scd_pkg::MASK_W-1:0]     rsp_expired_mask,
   output logic [scd_pkg::PHASE_W-1:0]    rsp_spinner_phase,
   output logic [scd_pkg::COUNT_W-1:0]    rsp_active_count
);

   localparam int GRP     = scd_pkg::GROUP_SIZE;
   localparam int NGROUPS = (SLOT_COUNT + GRP - 1) / GRP;
   localparam int PAD     = NGROUPS * GRP;
   localparam int GRP_W   = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
   localparam int LOC_W   = $clog2(GRP);
   localparam int FIND_W  = GRP_W + LOC_W;
   localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
   localparam int GCNT_W  = $clog2(GRP + 1);
   localparam int DUR_W   = scd_pkg::DUR_W;
   localparam int IDX_W   = scd_pkg::SLOT_IDX_W;
   localparam int MASK_W  = scd_pkg::MASK_W;
   localparam int PH_W    = scd_pkg::PHASE_W;
   localparam int OCNT_W  = scd_pkg::COUNT_W;

   // bank state
   logic [DUR_W-1:0]      rem_ff [SLOT_COUNT];
   logic [DUR_W-1:0]      rem_in [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] busy_ff, busy_in;
   logic [PH_W-1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0]      total_ff, total_in;

   // captured word and first tree level
   logic                  mode_ff;
   logic [DUR_W-1:0]      dur_ff;
   logic [SLOT_COUNT-1:0] exp_ff, exp_now;
   logic [NGROUPS-1:0]    gfree_ff, gfree_in;
   logic [LOC_W-1:0]      gloc_ff [NGROUPS];
   logic [LOC_W-1:0]      gloc_in [NGROUPS];
   logic [GCNT_W-1:0]     gcnt_ff [NGROUPS];
   logic [GCNT_W-1:0]     gcnt_in [NGROUPS];

   logic [PAD-1:0]        busy_pad, exp_pad;

   // second tree level
   logic                  found;
   logic [FIND_W-1:0]     fidx;
   logic [CNT_W-1:0]      exp_total;

   // response registers
   logic [IDX_W-1:0]      slot_ff, slot_in;
   logic                  acc_ff, acc_in;
   logic                  full_ff, full_in;
   logic                  done_ff, done_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;

   logic [FIND_W+IDX_W-1:0]       fidx_wide;
   logic [SLOT_COUNT+MASK_W-1:0]  mask_wide;
   logic [CNT_W+OCNT_W-1:0]       count_wide;

   // a busy slot expires on this tick when it holds one (or zero)
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         exp_now[i] = busy_ff[i] && (rem_ff[i][DUR_W-1:1] == '0);
      end
      busy_pad = '1;
      busy_pad[SLOT_COUNT-1:0] = busy_ff;
      exp_pad = '0;
      exp_pad[SLOT_COUNT-1:0] = exp_now;
   end

   // per group: lowest free slot and expiry count
   always_comb begin
      for (int g = 0; g < NGROUPS; g++) begin
         gfree_in[g] = 1'b0;
         gloc_in[g]  = '0;
         gcnt_in[g]  = '0;
         for (int k = GRP - 1; k >= 0; k--) begin
            if (!busy_pad[g*GRP + k]) begin
               gfree_in[g] = 1'b1;
               gloc_in[g]  = LOC_W'(k);
            end
            gcnt_in[g] = gcnt_in[g] + GCNT_W'(exp_pad[g*GRP + k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         dur_ff   <= req_duration;
         exp_ff   <= exp_now;
         gfree_ff <= gfree_in;
         gloc_ff  <= gloc_in;
         gcnt_ff  <= gcnt_in;
      end
   end

   always_comb begin
      found     = 1'b0;
      fidx      = '0;
      exp_total = '0;
      for (int g = NGROUPS - 1; g >= 0; g--) begin
         if (gfree_ff[g]) begin
            found = 1'b1;
            fidx  = {GRP_W'(g), gloc_ff[g]};
         end
      end
      for (int g = 0; g < NGROUPS; g++) begin
         exp_total = exp_total + CNT_W'(gcnt_ff[g]);
      end
   end

   assign fidx_wide = (FIND_W + IDX_W)'(fidx);
   assign mask_wide = (SLOT_COUNT + MASK_W)'(exp_ff);

   always_comb begin
      rem_in   = rem_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      total_in = total_ff;
      slot_in  = slot_ff;
      acc_in   = acc_ff;
      full_in  = full_ff;
      done_in  = done_ff;
      mask_in  = mask_ff;
      if (cmd.commit) begin
         slot_in = '0;
         acc_in  = 1'b0;
         full_in = 1'b0;
         done_in = 1'b0;
         mask_in = '0;
         if (mode_ff == scd_pkg::MODE_START) begin
            if (dur_ff == '0) begin
               done_in = 1'b1;
            end else if (found) begin
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (fidx == FIND_W'(i)) begin
                     busy_in[i] = 1'b1;
                     rem_in[i]  = dur_ff;
                  end
               end
               total_in = total_ff + CNT_W'(1);
               slot_in  = fidx_wide[IDX_W-1:0];
               acc_in   = 1'b1;
            end else begin
               full_in = 1'b1;
            end
         end else begin
            phase_in = phase_ff + PH_W'(1);
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (busy_ff[i] && (rem_ff[i] != '0)) begin
                  rem_in[i] = rem_ff[i] - DUR_W'(1);
               end
            end
            busy_in  = busy_ff & ~exp_ff;
            total_in = total_ff - exp_total;
            mask_in  = mask_wide[MASK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= '0;
         phase_ff <= '0;
         total_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      slot_ff <= slot_in;
      acc_ff  <= acc_in;
      full_ff <= full_in;
      done_ff <= done_in;
      mask_ff <= mask_in;
   end

   assign count_wide = (CNT_W + OCNT_W)'(total_ff);

   assign rsp_slot_index    = slot_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_full_res      = full_ff;
   assign rsp_done_now      = done_ff;
   assign rsp_expired_mask  = mask_ff;
   assign rsp_spinner_phase = phase_ff;
   assign rsp_active_count  = count_wide[OCNT_W-1:0];

endmodule

>>> design/scd_ctrl.sv
// controller: capture and commit sequencing and response valid
`timescale 1ns / 1ps

module scd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output scd_pkg::cmd_type cmd
);

   scd_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scd_pkg::ST_IDLE: begin
            if (req_valid) state_in = scd_pkg::ST_COMMIT;
         end
         scd_pkg::ST_COMMIT: begin
            if (rsp_free) state_in = scd_pkg::ST_IDLE;
         end
         default: state_in = scd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         scd_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         scd_pkg::ST_COMMIT: begin
            cmd.commit = rsp_free;
         end
         default: ;
      endcase
   end

   // a new result replaces one that is being taken in the same cycle
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/sleep_countdown_slots_unit.sv
// top level of the sleep countdown slot bank
//
//  channel   dir  payload                                          handshake
//  req_chan  in   mode, duration                                   valid / ready
//  rsp_chan  out  slot_index, accepted, full_res, done_now,        valid / ready
//                 expired_mask, spinner_phase, active_count
//
// each word is registered at the accept edge together with the per-group
// free-slot search and expiry counts; as the second step the commit edge settles the bank and loads the result
// that second step is held while the previous result still waits to be taken
// a new word is accepted while a finished result waits at the output
// synchronous reset clears busy bits, spinner phase, busy count and the controller
`timescale 1ns / 1ps

module sleep_countdown_slots_unit #(
   parameter int SLOT_COUNT = scd_pkg::SLOT_COUNT_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   scd_req_if.sink    req_chan,
   scd_rsp_if.source  rsp_chan
);

   scd_pkg::cmd_type cmd;

   scd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   scd_datapath #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_mode          (req_chan.mode),
      .req_duration      (req_chan.duration),
      .rsp_slot_index    (rsp_chan.slot_index),
      .rsp_accepted      (rsp_chan.accepted),
      .rsp_full_res      (rsp_chan.full_res),
      .rsp_done_now      (rsp_chan.done_now),
      .rsp_expired_mask  (rsp_chan.expired_mask),
      .rsp_spinner_phase (rsp_chan.spinner_phase),
      .rsp_active_count  (rsp_chan.active_count)
   );

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_chan.valid)
      else $error("committed word did not show at the output");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second word taken before the first was committed");

   a_outcome_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $onehot0({rsp_chan.accepted, rsp_chan.full_res, rsp_chan.done_now}))
      else $error("more than one start outcome flagged");

   a_tick_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.expired_mask != '0)) |->
         (!rsp_chan.accepted && !rsp_chan.full_res && !rsp_chan.done_now))
      else $error("expiry mask on a start result");

endmodule

>>> tb/tb.sv
// self-checking bench for the sleep countdown slot bank: shadow slot model, random traffic
`timescale 1ns / 1ps

module tb;

   localparam int NSLOT = scd_pkg::SLOT_COUNT_DEFAULT;
   localparam int WORDS_WANTED = 1300;

   localparam int DUR_W      = scd_pkg::DUR_W;
   localparam int SLOT_IDX_W = scd_pkg::SLOT_IDX_W;
   localparam int MASK_W     = scd_pkg::MASK_W;
   localparam int PHASE_W    = scd_pkg::PHASE_W;
   localparam int COUNT_W    = scd_pkg::COUNT_W;

   typedef struct packed {
      logic [SLOT_IDX_W-1:0] slot_index;
      logic                  accepted;
      logic                  full_res;
      logic                  done_now;
      logic [MASK_W-1:0]     expired_mask;
      logic [PHASE_W-1:0]    spinner_phase;
      logic [COUNT_W-1:0]    active_count;
   } reply_type;

   // shadow copy of the slot bank plus the replies it still owes
   class countdown_slots;
      logic [DUR_W-1:0]   ticks_left[NSLOT];
      bit                 busy[NSLOT];
      logic [PHASE_W-1:0] phase;
      int                 busy_cnt;
      reply_type          replies_due[$];
      int                 bad_replies;
      int                 ticks_seen, starts_seen, full_seen, done_seen, expiries_seen;
      int                 peak_busy;

      function new();
         foreach (busy[i]) begin
            busy[i] = 0;
            ticks_left[i] = '0;
         end
         phase = '0;
         busy_cnt = 0;
         bad_replies = 0;
         ticks_seen = 0;
         starts_seen = 0;
         full_seen = 0;
         done_seen = 0;
         expiries_seen = 0;
         peak_busy = 0;
      endfunction

      function void apply_word(logic m, logic [DUR_W-1:0] d);
         reply_type r;
         int        found;
         r = '0;
         found = -1;
         if (m == scd_pkg::MODE_START) begin
            starts_seen++;
            if (d == '0) begin
               r.done_now = 1'b1;
               done_seen++;
            end else begin
               for (int i = 0; i < NSLOT; i++) begin
                  if (!busy[i] && found < 0) found = i;
               end
               if (found < 0) begin
                  r.full_res = 1'b1;
                  full_seen++;
               end else begin
                  busy[found] = 1;
                  ticks_left[found] = d;
                  busy_cnt++;
                  r.slot_index = found[SLOT_IDX_W-1:0];
                  r.accepted = 1'b1;
               end
            end
         end else begin
            ticks_seen++;
            phase = phase + 1'b1;
            for (int i = 0; i < NSLOT; i++) begin
               if (busy[i]) begin
                  if (ticks_left[i] != '0) ticks_left[i] = ticks_left[i] - 1'b1;
                  if (ticks_left[i] == '0) begin
                     busy[i] = 0;
                     if (busy_cnt > 0) busy_cnt--;
                     if (i < MASK_W) r.expired_mask[i] = 1'b1;
                  end
               end
            end
            expiries_seen += $countones(r.expired_mask);
         end
         if (busy_cnt > peak_busy) peak_busy = busy_cnt;
         r.spinner_phase = phase;
         r.active_count = busy_cnt[COUNT_W-1:0];
         replies_due.push_back(r);
      endfunction

      function void check_reply(reply_type got);
         reply_type want;
         if (replies_due.size() == 0) begin
            bad_replies++;
            if (bad_replies <= 10)
               $display({"%0t: reply with nothing outstanding: slot %0d acc %b full %b",
                         " done %b mask %h phase %0d count %0d"},
                        $realtime, got.slot_index, got.accepted, got.full_res, got.done_now,
                        got.expired_mask, got.spinner_phase, got.active_count);
            return;
         end
         want = replies_due.pop_front();
         if (got.slot_index !== want.slot_index || got.accepted !== want.accepted ||
             got.full_res !== want.full_res || got.done_now !== want.done_now ||
             got.expired_mask !== want.expired_mask ||
             got.spinner_phase !== want.spinner_phase ||
             got.active_count !== want.active_count) begin
            bad_replies++;
            if (bad_replies <= 10) begin
               $display("%0t: reply mismatch", $realtime);
               $display("   expected slot %0d acc %b full %b done %b mask %h phase %0d count %0d",
                        want.slot_index, want.accepted, want.full_res, want.done_now,
                        want.expired_mask, want.spinner_phase, want.active_count);
               $display("   actual   slot %0d acc %b full %b done %b mask %h phase %0d count %0d",
                        got.slot_index, got.accepted, got.full_res, got.done_now,
                        got.expired_mask, got.spinner_phase, got.active_count);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   quiet = 0;
   int   words_sent = 0;
   int   long_held = 0;

   scd_req_if req_chan ();
   scd_rsp_if rsp_chan ();

   countdown_slots slots = new();

   sleep_countdown_slots_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_word(input logic m, input logic [DUR_W-1:0] d);
      while (!quiet && $urandom_range(99) < 19) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.mode <= m;
      req_chan.duration <= d;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      slots.apply_word(m, d);
      words_sent++;
   endtask

   // mostly short countdowns that expire during the run, a few that never do
   function automatic logic [DUR_W-1:0] pick_duration();
      int roll;
      roll = $urandom_range(99);
      if (roll < 6) return '0;
      if (roll < 9 && long_held < 6) begin
         long_held++;
         return $urandom | 32'h0001_0000;
      end
      return $urandom_range(30, 1);
   endfunction

   initial begin
      int roll;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.mode = scd_pkg::MODE_TICK;
      req_chan.duration = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed opening
      send_word(scd_pkg::MODE_TICK, '0);
      send_word(scd_pkg::MODE_START, '0);
      send_word(scd_pkg::MODE_START, 32'd1);
      send_word(scd_pkg::MODE_TICK, 32'hFFFF_FFFF);  // duration ignored on a tick
      send_word(scd_pkg::MODE_START, 32'hFFFF_FFFF);
      long_held++;
      send_word(scd_pkg::MODE_START, 32'd1);
      send_word(scd_pkg::MODE_START, 32'd2);
      send_word(scd_pkg::MODE_START, 32'd1);
      send_word(scd_pkg::MODE_TICK, '0);             // two slots expire together
      send_word(scd_pkg::MODE_START, 32'd5);         // reuses the lowest freed slot
      send_word(scd_pkg::MODE_START, 32'hAAAA_5555);
      long_held++;
      send_word(scd_pkg::MODE_START, 32'd3);
      send_word(scd_pkg::MODE_TICK, '0);
      send_word(scd_pkg::MODE_TICK, '0);
      send_word(scd_pkg::MODE_TICK, '0);
      send_word(scd_pkg::MODE_TICK, '0);             // spinner back at phase 3
      send_word(scd_pkg::MODE_START, '0);
      send_word(scd_pkg::MODE_TICK, '0);
      send_word(scd_pkg::MODE_TICK, '0);

      while (words_sent < WORDS_WANTED) begin
         quiet = (words_sent >= 450 && words_sent < 700);
         roll = $urandom_range(99);
         if (roll < 15) begin
            // fill the bank, run into full, at random a zero duration while full, then drain a bit
            repeat ($urandom_range(36, 30))
               send_word(scd_pkg::MODE_START, $urandom_range(8, 1));
            if ($urandom_range(1, 0)) send_word(scd_pkg::MODE_START, '0);
            send_word(scd_pkg::MODE_START, $urandom_range(8, 1));
            repeat ($urandom_range(10, 3)) send_word(scd_pkg::MODE_TICK, $urandom);
         end else if (roll < 27) begin
            repeat ($urandom_range(25, 4)) send_word(scd_pkg::MODE_TICK, $urandom);
         end else begin
            repeat (12) begin
               if ($urandom_range(99) < 50) send_word(scd_pkg::MODE_TICK, $urandom);
               else send_word(scd_pkg::MODE_START, pick_duration());
            end
         end
      end

      quiet = 0;
      req_chan.valid <= 1'b0;
      while (slots.replies_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("%0d words: %0d ticks, %0d starts (%0d full, %0d zero duration), %0d expiries",
               words_sent, slots.ticks_seen, slots.starts_seen, slots.full_seen,
               slots.done_seen, slots.expiries_seen);
      $display("peak slots busy %0d, replies in error %0d", slots.peak_busy, slots.bad_replies);
      if (slots.bad_replies == 0 && slots.replies_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // reply side: sample at the edge, then pick the next ready
   initial begin
      reply_type got;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.slot_index = rsp_chan.slot_index;
            got.accepted = rsp_chan.accepted;
            got.full_res = rsp_chan.full_res;
            got.done_now = rsp_chan.done_now;
            got.expired_mask = rsp_chan.expired_mask;
            got.spinner_phase = rsp_chan.spinner_phase;
            got.active_count = rsp_chan.active_count;
            slots.check_reply(got);
         end
         rsp_chan.ready <= (quiet || $urandom_range(99) >= 19);
      end
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d replies outstanding", slots.replies_due.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
